FILE: rtl/core/kne_pkg.sv
package kne_pkg;

	localparam int unsigned QDEPTH = 4;
	localparam int unsigned QPTR_W = $clog2(QDEPTH);
	localparam int unsigned QCNT_W = $clog2(QDEPTH + 1);

	localparam logic [7:0] SEP_RESET = 8'h2F;
	localparam logic [7:0] CH_SLASH  = 8'h2F;
	localparam logic [7:0] CH_PCT    = 8'h25;
	localparam logic [7:0] CH_PLUS   = 8'h2B;
	localparam logic [7:0] CH_BSL    = 8'h5C;
	localparam logic [7:0] CH_SPACE  = 8'h20;
	localparam logic [7:0] CH_NUL    = 8'h00;
	localparam logic [7:0] CH_2      = 8'h32;
	localparam logic [7:0] CH_5      = 8'h35;
	localparam logic [7:0] CH_B      = 8'h42;
	localparam logic [7:0] CH_C      = 8'h43;
	localparam logic [7:0] CH_F      = 8'h46;

	localparam logic [1:0] IDX_FIRST = 2'd0;
	localparam logic [1:0] IDX_MID   = 2'd1;
	localparam logic [1:0] IDX_LAST  = 2'd2;

	// one queued job: up to three bytes, or a terminator with status
	typedef struct packed {
		logic [7:0]  b0;
		logic [7:0]  b1;
		logic [7:0]  b2;
		logic        three;
		logic        fin;
		logic        fail;
		logic [15:0] written;
	} entry_t;

	typedef struct packed {
		logic full;
		logic empty;
	} qstat_t;

endpackage

FILE: rtl/core/kne_fifo.sv
module kne_fifo
	import kne_pkg::*;
(
	input  logic   clk,
	input  logic   arst_n,
	input  logic   push,
	input  entry_t wr_entry,
	input  logic   pop,
	output entry_t rd_entry,
	output qstat_t stat
);

	entry_t              mem_q [QDEPTH];
	logic [QPTR_W-1:0]   wr_ptr_q;
	logic [QPTR_W-1:0]   rd_ptr_q;
	logic [QCNT_W-1:0]   count_q;

	assign stat.full  = (count_q == QCNT_W'(QDEPTH));
	assign stat.empty = (count_q == '0);
	assign rd_entry   = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= wr_entry;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	a_count_range: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= QCNT_W'(QDEPTH))
		else $error("queue count out of range");

	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		stat.full |-> !push)
		else $error("push into full queue");

	a_no_underflow: assert property (@(posedge clk) disable iff (!arst_n)
		stat.empty |-> !pop)
		else $error("pop from empty queue");

endmodule

FILE: rtl/core/kne_front.sv
module kne_front
	import kne_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_valid,
	input  logic [7:0]  cfg_data,
	input  logic        accept,
	input  logic [7:0]  ch,
	input  logic        first,
	input  logic        end_of_name,
	input  logic [15:0] capacity,
	output logic        push,
	output entry_t      entry
);

	logic [7:0]  sep_q;
	logic [15:0] budget_q;
	logic [15:0] wrcnt_q;
	logic        after_bsl_q;
	logic        err_q;

	logic [15:0] bl;
	logic [15:0] bw;
	logic        ab;
	logic        err;
	logic        fail;
	logic        no_room;
	logic [1:0]  len;

	always_comb begin
		bl  = first ? capacity : budget_q;
		bw  = first ? 16'd0 : wrcnt_q;
		ab  = first ? 1'b0 : after_bsl_q;
		err = first ? 1'b0 : err_q;

		fail = err || (bl == 16'd0);

		entry.b0      = ch;
		entry.b1      = CH_NUL;
		entry.b2      = CH_NUL;
		entry.three   = 1'b0;
		entry.fin     = 1'b0;
		entry.fail    = 1'b0;
		entry.written = 16'd0;

		if (end_of_name) begin
			entry.b0      = CH_NUL;
			entry.fin     = 1'b1;
			entry.fail    = fail;
			entry.written = fail ? 16'd0 : bw + 16'd1;
		end else if (ch == sep_q && !ab) begin
			entry.b0 = ch;
		end else if (ch == sep_q || ch == CH_SLASH) begin
			entry.b0 = CH_PCT; entry.b1 = CH_2; entry.b2 = CH_F; entry.three = 1'b1;
		end else if (ch == CH_PCT) begin
			entry.b0 = CH_PCT; entry.b1 = CH_2; entry.b2 = CH_5; entry.three = 1'b1;
		end else if (ch == CH_PLUS) begin
			entry.b0 = CH_PCT; entry.b1 = CH_2; entry.b2 = CH_B; entry.three = 1'b1;
		end else if (ch == CH_BSL) begin
			entry.b0 = CH_PCT; entry.b1 = CH_5; entry.b2 = CH_C; entry.three = 1'b1;
		end else if (ch == CH_SPACE) begin
			entry.b0 = CH_PLUS;
		end

		len     = entry.three ? 2'd3 : 2'd1;
		no_room = (bl < 16'd2) || (entry.three && bl < 16'd3);
		push    = accept && (end_of_name || (!err && !no_room));
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sep_q       <= SEP_RESET;
			budget_q    <= '0;
			wrcnt_q     <= '0;
			after_bsl_q <= 1'b0;
			err_q       <= 1'b0;
		end else begin
			if (cfg_valid) begin
				sep_q <= cfg_data;
			end
			if (accept) begin
				budget_q    <= bl;
				wrcnt_q     <= bw;
				after_bsl_q <= ab;
				err_q       <= err;
				if (end_of_name) begin
					after_bsl_q <= 1'b0;
				end else if (!err) begin
					if (no_room) begin
						err_q <= 1'b1;
					end else begin
						after_bsl_q <= (ch == CH_BSL);
						budget_q    <= bl - {14'd0, len};
						wrcnt_q     <= bw + {14'd0, len};
					end
				end
			end
		end
	end

	a_end_always_pushes: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && end_of_name) |-> (push && entry.fin))
		else $error("end word not queued");

endmodule

FILE: rtl/core/kne_back.sv
module kne_back
	import kne_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  entry_t      head,
	input  qstat_t      qstat,
	output logic        pop,
	input  logic        m_tready,
	output logic        m_tvalid,
	output logic [31:0] m_tdata,
	output logic        m_tuser,
	output logic        m_tlast
);

	logic [1:0]  idx_q;
	logic        m_tvalid_q;
	logic [7:0]  byte_q;
	logic        fin_q;
	logic        fail_q;
	logic [15:0] written_q;
	logic        last_q;

	logic        load;
	logic        last_word;
	logic [7:0]  sel_byte;

	always_comb begin
		case (idx_q)
			IDX_FIRST: sel_byte = head.b0;
			IDX_MID:   sel_byte = head.b1;
			default:   sel_byte = head.b2;
		endcase
		load      = (!m_tvalid_q || m_tready) && !qstat.empty;
		last_word = head.fin || !head.three || (idx_q == IDX_LAST);
		pop       = load && last_word;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idx_q      <= IDX_FIRST;
			m_tvalid_q <= 1'b0;
		end else begin
			if (load) begin
				m_tvalid_q <= 1'b1;
				idx_q      <= last_word ? IDX_FIRST : idx_q + 2'd1;
			end else if (m_tready) begin
				m_tvalid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			byte_q    <= sel_byte;
			fin_q     <= head.fin;
			fail_q    <= head.fail;
			written_q <= head.written;
			last_q    <= last_word;
		end
	end

	// tdata: out_byte [7:0], failed [8], written [24:9], zero pad
	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = {7'd0, written_q, fail_q, byte_q};
	assign m_tuser  = fin_q;
	assign m_tlast  = last_q;

	a_idx_range: assert property (@(posedge clk) disable iff (!arst_n)
		idx_q != 2'd3)
		else $error("byte index out of range");

	a_mid_entry_held: assert property (@(posedge clk) disable iff (!arst_n)
		(idx_q != IDX_FIRST) |-> (!qstat.empty && head.three && !head.fin))
		else $error("escape entry lost mid sequence");

endmodule

FILE: rtl/core/key_name_percent_escaper.sv
// Percent escaper for key names. Each input word carries one name byte
// (s_tuser marks the first byte and loads the budget from capacity, s_tlast
// marks the terminator word). The front stage classifies and budgets each
// accepted word and hands the escape job to a four-entry queue; the back stage
// sends one output byte per cycle while m_tready allows it, so a plain byte or
// the terminator gives one output byte and an escape gives three. The output
// byte port is what sets the sustained rate. The separator is set through the
// cfg port, reset value '/'.
module key_name_percent_escaper
	import kne_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [7:0]  cfg_data,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [23:0] s_tdata,  // ch [7:0], capacity [23:8]
	input  logic        s_tuser,  // first
	input  logic        s_tlast,
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [31:0] m_tdata,  // out_byte [7:0], failed [8], written [24:9]
	output logic        m_tuser,  // is_final
	output logic        m_tlast
);

	logic   accept;
	logic   push;
	logic   pop;
	entry_t wr_entry;
	entry_t head;
	qstat_t qstat;

	assign cfg_ready = 1'b1;
	assign s_tready  = !qstat.full;
	assign accept    = s_tvalid && s_tready;

	kne_front u_front (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_valid   (cfg_valid),
		.cfg_data    (cfg_data),
		.accept      (accept),
		.ch          (s_tdata[7:0]),
		.first       (s_tuser),
		.end_of_name (s_tlast),
		.capacity    (s_tdata[23:8]),
		.push        (push),
		.entry       (wr_entry)
	);

	kne_fifo u_fifo (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.wr_entry (wr_entry),
		.pop      (pop),
		.rd_entry (head),
		.stat     (qstat)
	);

	kne_back u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.head     (head),
		.qstat    (qstat),
		.pop      (pop),
		.m_tready (m_tready),
		.m_tvalid (m_tvalid),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser),
		.m_tlast  (m_tlast)
	);

endmodule

FILE: dv/tb_key_name_percent_escaper.sv
module tb_key_name_percent_escaper;
	import kne_pkg::*;

	localparam int CYCLE_LIMIT = 400000;
	localparam int WORD_TARGET = 280;

	typedef struct {
		logic [7:0]  out_byte;
		logic        fin;
		logic        fail;
		logic [15:0] written;
		logic        lst;
	} esc_byte_t;

	class escape_scoreboard;
		logic [7:0]  sep;
		logic [15:0] budget;
		logic [15:0] nbytes;
		bit          after_bsl;
		bit          overrun;
		esc_byte_t   want_q[$];
		int          errors;
		int          words_in;
		int          words_out;
		int          names;

		function new();
			sep = SEP_RESET;
			budget = '0;
			nbytes = '0;
			after_bsl = 0;
			overrun = 0;
			errors = 0;
			words_in = 0;
			words_out = 0;
			names = 0;
		endfunction

		function int pending();
			return want_q.size();
		endfunction

		function void set_sep(logic [7:0] v);
			sep = v;
		endfunction

		function void push(logic [7:0] b, logic fin, logic fail, logic [15:0] wr, logic lst);
			esc_byte_t e;
			e.out_byte = b;
			e.fin = fin;
			e.fail = fail;
			e.written = wr;
			e.lst = lst;
			want_q.push_back(e);
		endfunction

		function void note_word(logic [7:0] ch, logic first, logic eon, logic [15:0] cap);
			logic [7:0] seq [3];
			int         n;
			bit         fail;
			words_in++;
			if (first) begin
				budget = cap;
				nbytes = '0;
				after_bsl = 0;
				overrun = 0;
				names++;
			end
			if (eon) begin
				fail = overrun || budget == 16'd0;
				push(CH_NUL, 1'b1, fail, fail ? 16'd0 : 16'(nbytes + 16'd1), 1'b1);
				after_bsl = 0;
				return;
			end
			if (overrun)
				return;
			n = 3;
			seq[0] = CH_PCT;
			seq[1] = CH_2;
			seq[2] = CH_F;
			if (ch == sep && !after_bsl) begin
				seq[0] = ch;
				n = 1;
			end else if (ch == sep || ch == CH_SLASH) begin
				seq[2] = CH_F;
			end else if (ch == CH_PCT) begin
				seq[2] = CH_5;
			end else if (ch == CH_PLUS) begin
				seq[2] = CH_B;
			end else if (ch == CH_BSL) begin
				seq[1] = CH_5;
				seq[2] = CH_C;
			end else if (ch == CH_SPACE) begin
				seq[0] = CH_PLUS;
				n = 1;
			end else begin
				seq[0] = ch;
				n = 1;
			end
			if (budget < 16'd2 || budget < 16'(n)) begin
				overrun = 1;
				return;
			end
			after_bsl = (ch == CH_BSL);
			budget = budget - 16'(n);
			nbytes = nbytes + 16'(n);
			for (int i = 0; i < n; i++)
				push(seq[i], 1'b0, 1'b0, 16'd0, i == n - 1);
		endfunction

		function void cmp(string what, logic [15:0] exp_v, logic [15:0] act_v);
			if (act_v !== exp_v) begin
				errors++;
				$display("%0t: %s mismatch, expected %h, actual %h", $time, what, exp_v, act_v);
			end
		endfunction

		function void check_word(logic [31:0] data, logic fin, logic lst);
			esc_byte_t w;
			words_out++;
			if (want_q.size() == 0) begin
				errors++;
				$display("%0t: unexpected output word, expected none, actual %h", $time, data);
				return;
			end
			w = want_q.pop_front();
			cmp("out_byte", 16'(w.out_byte), 16'(data[7:0]));
			cmp("failed", 16'(w.fail), 16'(data[8]));
			cmp("written", w.written, data[24:9]);
			cmp("is_final", 16'(w.fin), 16'(fin));
			cmp("last", 16'(w.lst), 16'(lst));
		endfunction
	endclass

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        cfg_valid = 1'b0;
	logic        cfg_ready;
	logic [7:0]  cfg_data = '0;
	logic        s_tvalid = 1'b0;
	logic        s_tready;
	logic [23:0] s_tdata = '0;  // ch [7:0], capacity [23:8]
	logic        s_tuser = 1'b0;  // first
	logic        s_tlast = 1'b0;
	logic        m_tvalid;
	logic        m_tready = 1'b0;
	logic [31:0] m_tdata;  // out_byte [7:0], failed [8], written [24:9]
	logic        m_tuser;  // is_final
	logic        m_tlast;

	escape_scoreboard sb;
	bit idle_on = 1'b1;
	int cycles = 0;
	int ostall = 0;

	key_name_percent_escaper dut (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_data(cfg_data),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata(s_tdata),
		.s_tuser(s_tuser),
		.s_tlast(s_tlast),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata(m_tdata),
		.m_tuser(m_tuser),
		.m_tlast(m_tlast)
	);

	always #5 clk = ~clk;

	always @(posedge clk) begin
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("timeout after %0d cycles, %0d words outstanding", cycles, sb.pending());
			$display("** key_name_percent_escaper: FAILED **");
			$finish;
		end
	end

	// output backpressure in short bursts
	always @(posedge clk) begin
		if (ostall > 0)
			ostall--;
		else if (idle_on && $urandom_range(0, 4) == 0)
			ostall = $urandom_range(1, 5);
		m_tready <= (ostall == 0);
	end

	always @(posedge clk) begin
		if (arst_n && m_tvalid && m_tready)
			sb.check_word(m_tdata, m_tuser, m_tlast);
	end

	task automatic send_word(input logic [7:0] ch, input logic first, input logic eon,
			input logic [15:0] cap);
		if (idle_on && $urandom_range(0, 3) == 0) begin
			s_tvalid <= 1'b0;
			repeat ($urandom_range(1, 5)) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata <= {cap, ch};
		s_tuser <= first;
		s_tlast <= eon;
		do @(posedge clk); while (!s_tready);
		sb.note_word(ch, first, eon, cap);
	endtask

	task automatic drain_results();
		s_tvalid <= 1'b0;
		while (sb.pending() != 0) @(posedge clk);
		repeat (12) @(posedge clk);
	endtask

	task automatic write_separator(input logic [7:0] v);
		cfg_valid <= 1'b1;
		cfg_data <= v;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
		sb.set_sep(v);
	endtask

	function automatic logic [7:0] pick_char();
		case ($urandom_range(0, 11))
			0: return sb.sep;
			1: return CH_SLASH;
			2, 3: return CH_BSL;
			4: return CH_PCT;
			5: return CH_PLUS;
			6: return CH_SPACE;
			default: return 8'($urandom_range(0, 255));
		endcase
	endfunction

	function automatic logic [15:0] pick_cap();
		case ($urandom_range(0, 9))
			6, 7: return 16'($urandom_range(25, 80));
			8: return 16'($urandom_range(0, 65535));
			9: return $urandom_range(0, 1) ? 16'hFFFF : 16'h0000;
			default: return 16'($urandom_range(0, 24));
		endcase
	endfunction

	// mostly whole names; some lack the first or the end word
	task automatic feed_name();
		int          n;
		int          kind;
		logic [15:0] cap;
		kind = $urandom_range(0, 9);
		cap = pick_cap();
		n = $urandom_range(0, 12);
		if (kind == 2 || n == 0) begin
			send_word(pick_char(), 1'b1, 1'b1, cap);
			return;
		end
		send_word(pick_char(), kind != 0, 1'b0, cap);
		for (int i = 1; i < n; i++)
			send_word(pick_char(), 1'b0, 1'b0, 16'($urandom));
		if (kind != 1)
			send_word(8'($urandom), 1'b0, 1'b1, 16'($urandom));
	endtask

	initial begin
		logic [7:0] seps [5];
		int         target;
		sb = new();
		seps[0] = 8'h00;
		seps[1] = 8'hFF;
		seps[2] = CH_BSL;
		seps[3] = 8'($urandom_range(0, 255));
		seps[4] = CH_SLASH;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// terminator before any budget was loaded
		send_word(8'hA5, 1'b0, 1'b1, 16'h1234);
		// every escape, separator after backslash, byte extremes
		send_word(CH_PCT, 1'b1, 1'b0, 16'hFFFF);
		send_word(CH_PLUS, 1'b0, 1'b0, 16'h0000);
		send_word(CH_BSL, 1'b0, 1'b0, 16'h0000);
		send_word(CH_SLASH, 1'b0, 1'b0, 16'h0000);
		send_word(CH_SPACE, 1'b0, 1'b0, 16'h0000);
		send_word(CH_SLASH, 1'b0, 1'b0, 16'h0000);
		send_word(8'h00, 1'b0, 1'b0, 16'h0000);
		send_word(8'hFF, 1'b0, 1'b0, 16'h0000);
		send_word(CH_BSL, 1'b0, 1'b0, 16'h0000);
		send_word(8'h61, 1'b0, 1'b0, 16'h0000);
		send_word(8'h00, 1'b0, 1'b1, 16'h0000);
		// empty names
		send_word(8'h00, 1'b1, 1'b1, 16'd1);
		send_word(8'hFF, 1'b1, 1'b1, 16'd0);
		// budget edges
		send_word(CH_PCT, 1'b1, 1'b0, 16'd3);
		send_word(8'h00, 1'b0, 1'b1, 16'd0);
		send_word(CH_PCT, 1'b1, 1'b0, 16'd2);
		send_word(8'h61, 1'b0, 1'b0, 16'd0);
		send_word(8'h00, 1'b0, 1'b1, 16'd0);
		send_word(8'h61, 1'b1, 1'b0, 16'd3);
		send_word(8'h62, 1'b0, 1'b0, 16'd0);
		send_word(8'h00, 1'b0, 1'b1, 16'd0);
		send_word(8'h61, 1'b1, 1'b0, 16'd2);
		send_word(8'h62, 1'b0, 1'b0, 16'd0);
		send_word(8'h00, 1'b0, 1'b1, 16'd0);

		for (int p = 0; p < 5; p++) begin
			drain_results();
			write_separator(seps[p]);
			idle_on = (p != 4);
			target = 25 + (p + 1) * (WORD_TARGET - 25) / 5;
			while (sb.words_in < target)
				feed_name();
		end
		drain_results();

		$display("covered %0d input words in %0d names, %0d output words checked",
			sb.words_in, sb.names, sb.words_out);
		$display("separators 00, ff, 5c, %h and 2f, with budget overruns and backslash escapes",
			seps[3]);
		if (sb.errors == 0 && sb.pending() == 0) begin
			$display("** key_name_percent_escaper: PASSED **");
		end else begin
			$display("** key_name_percent_escaper: FAILED **");
		end
		$finish;
	end

endmodule

FILE: key_name_percent_escaper.f
rtl/core/kne_pkg.sv
rtl/core/kne_fifo.sv
rtl/core/kne_front.sv
rtl/core/kne_back.sv
rtl/core/key_name_percent_escaper.sv
dv/tb_key_name_percent_escaper.sv
